@@ rtl/core/wts_pkg.sv @@
`timescale 1ns / 1ps

package wts_pkg;

   // Field widths
   localparam int COORD_W   = 16;   // signed integer coordinate
   localparam int NORM_W    = 24;   // unsigned Q8.16 normalized coordinate
   localparam int CFG_W     = 9;    // width / height register
   localparam int CHAN_W    = 3;    // channel count register
   localparam int BYTE_W    = 8;
   localparam int TEXEL_W   = 32;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 2;

   // Parameter defaults
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // Transaction modes (code 3 is a no-op)
   localparam logic [MODE_W-1:0] MODE_READ_INT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ_NORM = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0]  WIDTH_RESET  = 9'd256;
   localparam logic [CFG_W-1:0]  HEIGHT_RESET = 9'd256;
   localparam logic [CHAN_W-1:0] CHAN_RESET   = 3'd4;

   // Texel formats
   localparam logic [CHAN_W-1:0] CHAN_GREY       = 3'd1;
   localparam logic [CHAN_W-1:0] CHAN_GREY_ALPHA = 3'd2;
   localparam logic [CHAN_W-1:0] CHAN_RGB        = 3'd3;
   localparam logic [CHAN_W-1:0] CHAN_RGBA       = 3'd4;

   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

endpackage

@@ rtl/core/wrapped_texel_store_unit.sv @@
`timescale 1ns / 1ps
// Each transaction waits on the bit-serial modulo in the wrap units, which works on
// DW = max(16, clog2(max dimension + 1) + 8) bits (17 at 256x256); normalized reads
// add a scaling multiply before it. Writes take the same path as integer reads.
// Throughput: one transaction at a time; the next is taken the cycle after it retires.
// Reset: registers go to 256 x 256 RGBA, then a clearing pass writes zero to all
// MAX_WIDTH*MAX_HEIGHT words before req_ready rises.
module wrapped_texel_store_unit #(
   parameter int MAX_WIDTH  = wts_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = wts_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [wts_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [wts_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [wts_pkg::COORD_W-1:0]  req_coord_y,
   input  logic [wts_pkg::NORM_W-1:0]          req_coord_s,
   input  logic [wts_pkg::NORM_W-1:0]          req_coord_t,
   input  logic [wts_pkg::BYTE_W-1:0]          req_write_red,
   input  logic [wts_pkg::BYTE_W-1:0]          req_write_green,
   input  logic [wts_pkg::BYTE_W-1:0]          req_write_blue,
   input  logic [wts_pkg::BYTE_W-1:0]          req_write_alpha,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wts_pkg::BYTE_W-1:0]          rsp_red,
   output logic [wts_pkg::BYTE_W-1:0]          rsp_green,
   output logic [wts_pkg::BYTE_W-1:0]          rsp_blue,
   output logic [wts_pkg::BYTE_W-1:0]          rsp_alpha,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [wts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wts_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int WBX   = $clog2(MAX_WIDTH + 1);
   localparam int WBY   = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = WBX + WBY;
   localparam int BW    = wts_pkg::BYTE_W;

   typedef enum logic [5:0] {
      T_CLEAR  = 6'b000001,
      T_IDLE   = 6'b000010,
      T_WRAP   = 6'b000100,
      T_ADDR   = 6'b001000,
      T_READ   = 6'b010000,
      T_MODIFY = 6'b100000
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [wts_pkg::CFG_W-1:0]  cfg_width_ff, cfg_width_in;
   logic [wts_pkg::CFG_W-1:0]  cfg_height_ff, cfg_height_in;
   logic [wts_pkg::CHAN_W-1:0] cfg_chan_ff, cfg_chan_in;
   logic [wts_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [BW-1:0] wr_r_ff, wr_r_in, wr_g_ff, wr_g_in;
   logic [BW-1:0] wr_b_ff, wr_b_in, wr_a_ff, wr_a_in;
   logic          xd_ff, xd_in, yd_ff, yd_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in;
   logic [BW-1:0] rsp_b_ff, rsp_b_in, rsp_a_ff, rsp_a_in;

   logic [WBX-1:0] eff_w;
   logic [WBY-1:0] eff_h;
   logic [wts_pkg::CHAN_W-1:0] eff_ch;

   logic           accept;
   logic           wrap_start;
   logic           is_norm;
   logic           x_done, y_done;
   logic [WBX-1:0] x_idx;
   logic [WBY-1:0] y_idx;
   logic [LW-1:0]  addr_sum;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [wts_pkg::TEXEL_W-1:0]   ram_wdata;
   logic                          ram_re;
   logic [wts_pkg::TEXEL_W-1:0]   ram_rdata;
   logic [wts_pkg::TEXEL_W-1:0]   merged;
   logic                          rsp_load;

   // Clamp registers to their usable ranges
   always_comb begin
      if (cfg_width_ff == '0) begin
         eff_w = WBX'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WBX'(MAX_WIDTH);
      end else begin
         eff_w = WBX'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         eff_h = WBY'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = WBY'(MAX_HEIGHT);
      end else begin
         eff_h = WBY'(cfg_height_ff);
      end
      if (cfg_chan_ff == '0) begin
         eff_ch = wts_pkg::CHAN_GREY;
      end else if (cfg_chan_ff > wts_pkg::CHAN_RGBA) begin
         eff_ch = wts_pkg::CHAN_RGBA;
      end else begin
         eff_ch = cfg_chan_ff;
      end
   end

   assign req_ready  = (state_ff == T_IDLE);
   assign accept     = req_valid && req_ready;
   assign is_norm    = (req_mode == wts_pkg::MODE_READ_NORM);
   assign wrap_start = accept && ((req_mode == wts_pkg::MODE_READ_INT) ||
                                  (req_mode == wts_pkg::MODE_WRITE) || is_norm);

   // Column and row wrap units run side by side
   wts_wrap #(
      .MAX_N (MAX_WIDTH)
   ) u_wrap_x (
      .clock      (clock),
      .reset      (reset),
      .start      (wrap_start),
      .is_norm    (is_norm),
      .coord_int  (req_coord_x),
      .coord_norm (req_coord_s),
      .divisor    (eff_w),
      .done       (x_done),
      .index      (x_idx)
   );

   wts_wrap #(
      .MAX_N (MAX_HEIGHT)
   ) u_wrap_y (
      .clock      (clock),
      .reset      (reset),
      .start      (wrap_start),
      .is_norm    (is_norm),
      .coord_int  (req_coord_y),
      .coord_norm (req_coord_t),
      .divisor    (eff_h),
      .done       (y_done),
      .index      (y_idx)
   );

   // Linear address, always below DEPTH
   assign addr_sum = LW'(y_idx) * LW'(eff_w) + LW'(x_idx);

   // Byte merge for writes: only bytes of the current format change
   always_comb begin
      merged = ram_rdata;
      merged[BW-1:0] = wr_r_ff;
      if (eff_ch == wts_pkg::CHAN_GREY_ALPHA) begin
         merged[2*BW-1:BW] = wr_a_ff;
      end else if (eff_ch >= wts_pkg::CHAN_RGB) begin
         merged[2*BW-1:BW]   = wr_g_ff;
         merged[3*BW-1:2*BW] = wr_b_ff;
         if (eff_ch == wts_pkg::CHAN_RGBA) begin
            merged[4*BW-1:3*BW] = wr_a_ff;
         end
      end
   end

   // Control sequence: clear, then read-modify-write per transaction.
   // One transaction in flight, so a write lands before the next read.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_chan_in   = cfg_chan_ff;
      mode_in       = mode_ff;
      wr_r_in       = wr_r_ff;
      wr_g_in       = wr_g_ff;
      wr_b_in       = wr_b_ff;
      wr_a_in       = wr_a_ff;
      xd_in         = xd_ff || x_done;
      yd_in         = yd_ff || y_done;
      addr_in       = addr_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = merged;
      ram_re        = 1'b0;
      rsp_load      = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            wts_pkg::CSR_IMAGE_WIDTH:   cfg_width_in  = csr_wdata;
            wts_pkg::CSR_IMAGE_HEIGHT:  cfg_height_in = csr_wdata;
            wts_pkg::CSR_CHANNEL_COUNT: cfg_chan_in   = csr_wdata[wts_pkg::CHAN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         T_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = T_IDLE;
            end
         end
         T_IDLE: begin
            if (wrap_start) begin
               mode_in  = req_mode;
               wr_r_in  = req_write_red;
               wr_g_in  = req_write_green;
               wr_b_in  = req_write_blue;
               wr_a_in  = req_write_alpha;
               xd_in    = 1'b0;
               yd_in    = 1'b0;
               state_in = T_WRAP;
            end
         end
         T_WRAP: begin
            if (xd_in && yd_in) begin
               state_in = T_ADDR;
            end
         end
         T_ADDR: begin
            addr_in  = addr_sum[AW-1:0];
            state_in = T_READ;
         end
         T_READ: begin
            ram_re   = 1'b1;
            state_in = T_MODIFY;
         end
         T_MODIFY: begin
            if (mode_ff == wts_pkg::MODE_WRITE) begin
               ram_we   = 1'b1;
               state_in = T_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Read expansion to RGBA
   always_comb begin
      rsp_r_in = rsp_r_ff;
      rsp_g_in = rsp_g_ff;
      rsp_b_in = rsp_b_ff;
      rsp_a_in = rsp_a_ff;
      if (rsp_load) begin
         rsp_r_in = ram_rdata[BW-1:0];
         unique case (eff_ch)
            wts_pkg::CHAN_GREY: begin
               rsp_g_in = ram_rdata[BW-1:0];
               rsp_b_in = ram_rdata[BW-1:0];
               rsp_a_in = wts_pkg::ALPHA_OPAQUE;
            end
            wts_pkg::CHAN_GREY_ALPHA: begin
               rsp_g_in = ram_rdata[BW-1:0];
               rsp_b_in = ram_rdata[BW-1:0];
               rsp_a_in = ram_rdata[2*BW-1:BW];
            end
            wts_pkg::CHAN_RGB: begin
               rsp_g_in = ram_rdata[2*BW-1:BW];
               rsp_b_in = ram_rdata[3*BW-1:2*BW];
               rsp_a_in = wts_pkg::ALPHA_OPAQUE;
            end
            default: begin
               rsp_g_in = ram_rdata[2*BW-1:BW];
               rsp_b_in = ram_rdata[3*BW-1:2*BW];
               rsp_a_in = ram_rdata[4*BW-1:3*BW];
            end
         endcase
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_CLEAR;
         clr_cnt_ff    <= '0;
         cfg_width_ff  <= wts_pkg::WIDTH_RESET;
         cfg_height_ff <= wts_pkg::HEIGHT_RESET;
         cfg_chan_ff   <= wts_pkg::CHAN_RESET;
         xd_ff         <= 1'b0;
         yd_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         cfg_chan_ff   <= cfg_chan_in;
         xd_ff         <= xd_in;
         yd_ff         <= yd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff  <= mode_in;
      wr_r_ff  <= wr_r_in;
      wr_g_ff  <= wr_g_in;
      wr_b_ff  <= wr_b_in;
      wr_a_ff  <= wr_a_in;
      addr_ff  <= addr_in;
      rsp_r_ff <= rsp_r_in;
      rsp_g_ff <= rsp_g_in;
      rsp_b_ff <= rsp_b_in;
      rsp_a_ff <= rsp_a_in;
   end

   // Texel store
   wts_ram #(
      .WIDTH (wts_pkg::TEXEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_r_ff;
   assign rsp_green = rsp_g_ff;
   assign rsp_blue  = rsp_b_ff;
   assign rsp_alpha = rsp_a_ff;

   // Checks
   a_store_write_src: assert property (@(posedge clock) disable iff (reset)
      (ram_we && (state_ff != T_CLEAR)) |->
         ((state_ff == T_MODIFY) && (mode_ff == wts_pkg::MODE_WRITE)))
      else $error("store written outside a write transaction");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      x_done |-> (x_idx < eff_w))
      else $error("wrapped column not below image width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      y_done |-> (y_idx < eff_h))
      else $error("wrapped row not below image height");

   a_modify_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_MODIFY) |->
         (($past(state_ff) == T_READ) || ($past(state_ff) == T_MODIFY)))
      else $error("modify stage entered without a store read");

endmodule

@@ rtl/core/wts_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module wts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/wts_wrap.sv @@
`timescale 1ns / 1ps

// Coordinate wrap unit: maps an integer or normalized coordinate to an
// index in [0, divisor). Normalized input is scaled by one multiply, then a
// restoring divider retires one quotient bit per cycle to get the remainder.
module wts_wrap #(
   parameter int MAX_N = wts_pkg::MAX_WIDTH_DEF,
   localparam int NW = $clog2(MAX_N + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              is_norm,
   input  logic signed [wts_pkg::COORD_W-1:0] coord_int,
   input  logic [wts_pkg::NORM_W-1:0]         coord_norm,
   input  logic [NW-1:0]                      divisor,
   output logic                              done,
   output logic [NW-1:0]                      index
);

   localparam int DW = (NW + 8 > wts_pkg::COORD_W) ? NW + 8 : wts_pkg::COORD_W;
   localparam int PW = wts_pkg::NORM_W + NW;
   localparam int FW = PW + 10;          // product scaled by 1024
   localparam int CW = $clog2(DW);

   typedef enum logic [3:0] {
      W_IDLE = 4'b0001,
      W_MUL  = 4'b0010,
      W_DIV  = 4'b0100,
      W_FIX  = 4'b1000
   } wrap_state_type;

   wrap_state_type state_ff, state_in;
   logic [NW-1:0]  n_ff, n_in;
   logic           neg_ff, neg_in;
   logic [wts_pkg::NORM_W-1:0] q_ff, q_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic [DW-1:0]  dvd_ff, dvd_in;
   logic [NW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           done_ff, done_in;
   logic [NW-1:0]  idx_ff, idx_in;

   logic [wts_pkg::COORD_W-1:0] mag;
   logic [FW-1:0]  scaled;
   logic [NW:0]    trial;

   always_comb begin
      mag    = coord_int[wts_pkg::COORD_W-1] ? wts_pkg::COORD_W'(-coord_int)
                                             : wts_pkg::COORD_W'(coord_int);
      // q*n*1024 - q, then drop 26 fraction bits
      scaled = {prod_ff, 10'b0} - FW'(q_ff);
      trial  = {rem_ff, dvd_ff[DW-1]};

      state_in = state_ff;
      n_in     = n_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      prod_in  = prod_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      idx_in   = idx_ff;

      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               n_in    = divisor;
               rem_in  = '0;
               cnt_in  = CW'(DW - 1);
               q_in    = coord_norm;
               prod_in = PW'(coord_norm) * PW'(divisor);
               if (is_norm) begin
                  neg_in   = 1'b0;
                  state_in = W_MUL;
               end else begin
                  neg_in   = coord_int[wts_pkg::COORD_W-1];
                  dvd_in   = DW'(mag);
                  state_in = W_DIV;
               end
            end
         end
         W_MUL: begin
            dvd_in   = DW'(scaled[FW-1:26]);
            state_in = W_DIV;
         end
         W_DIV: begin
            // restoring step
            if (trial >= {1'b0, n_ff}) begin
               rem_in = NW'(trial - {1'b0, n_ff});
            end else begin
               rem_in = trial[NW-1:0];
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = W_FIX;
            end
         end
         W_FIX: begin
            // true modulo for negative coordinates
            idx_in   = (neg_ff && (rem_ff != '0)) ? n_ff - rem_ff : rem_ff;
            done_in  = 1'b1;
            state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff    <= n_in;
      neg_ff  <= neg_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
   end

   assign done  = done_ff;
   assign index = idx_ff;

endmodule
